// ----- rtl/rts_pkg.sv -----
package rts_pkg;

   localparam int MAX_COLS      = 8;
   localparam int MAX_ROWS      = 8;
   localparam int MAX_TILE_LOG2 = 11;

   localparam int LOG2_W  = 4;
   localparam int COUNT_W = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 4;
   localparam int COORD_W = 15;
   localparam int SIZE_W  = MAX_TILE_LOG2 + 1;
   localparam int OFF_W   = MAX_TILE_LOG2;
   localparam int FIX_W   = 17;
   localparam int FRAC_W  = 16;
   localparam int POS_W   = 16;
   localparam int IDX_W   = 6;
   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int SH_W    = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_INNER_W_LOG2 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_H_LOG2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_W_LOG2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_H_LOG2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_COLS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_ROWS    = 3'd5;

   // Grid setup after clamping to the supported ranges.
   typedef struct packed {
      logic [LOG2_W-1:0]  iwl;
      logic [LOG2_W-1:0]  ihl;
      logic [LOG2_W-1:0]  ewl;
      logic [LOG2_W-1:0]  ehl;
      logic [COUNT_W-1:0] cols;
      logic [COUNT_W-1:0] rows;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic row_load;
      logic piece_take;
      logic row_next;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic y_done;
      logic row_ok;
      logic col_ok;
   } status_type;

   function automatic logic [LOG2_W-1:0] clamp_log2(input logic [LOG2_W-1:0] v);
      logic [LOG2_W-1:0] lim;
      lim = LOG2_W'(MAX_TILE_LOG2);
      return (v > lim) ? lim : v;
   endfunction

   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                      input logic [COUNT_W-1:0] lim);
      logic [COUNT_W-1:0] r;
      if (v == '0) begin
         r = COUNT_W'(1);
      end else if (v > lim) begin
         r = lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Offset over tile size in 16-bit fraction fixed point; exact for a power-of-two size.
   function automatic logic [FIX_W-1:0] to_fix(input logic [SIZE_W-1:0] off,
                                               input logic [LOG2_W-1:0] lg);
      logic [FIX_W+SIZE_W-1:0] wide;
      logic [SH_W-1:0]         sh;
      sh   = SH_W'(FRAC_W) - SH_W'(lg);
      wide = (FIX_W+SIZE_W)'(off) << sh;
      return wide[FIX_W-1:0];
   endfunction

endpackage

// ----- rtl/rts_csr.sv -----
module rts_csr
   import rts_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output cfg_type              cfg
);

   logic [LOG2_W-1:0]  iwl_ff, ihl_ff, ewl_ff, ehl_ff;
   logic [COUNT_W-1:0] cols_ff, rows_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         iwl_ff  <= LOG2_W'(6);
         ihl_ff  <= LOG2_W'(6);
         ewl_ff  <= LOG2_W'(6);
         ehl_ff  <= LOG2_W'(6);
         cols_ff <= COUNT_W'(1);
         rows_ff <= COUNT_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INNER_W_LOG2: iwl_ff  <= csr_wdata;
            CSR_INNER_H_LOG2: ihl_ff  <= csr_wdata;
            CSR_EDGE_W_LOG2:  ewl_ff  <= csr_wdata;
            CSR_EDGE_H_LOG2:  ehl_ff  <= csr_wdata;
            CSR_TILE_COLS:    cols_ff <= csr_wdata;
            CSR_TILE_ROWS:    rows_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.iwl  = clamp_log2(iwl_ff);
      cfg.ihl  = clamp_log2(ihl_ff);
      cfg.ewl  = clamp_log2(ewl_ff);
      cfg.ehl  = clamp_log2(ehl_ff);
      cfg.cols = clamp_count(cols_ff, COUNT_W'(MAX_COLS));
      cfg.rows = clamp_count(rows_ff, COUNT_W'(MAX_ROWS));
   end

endmodule

// ----- rtl/rts_ctrl.sv -----
module rts_ctrl
   import rts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type st,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      IDLE,
      ROW,
      COL,
      FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               busy_in  = 1'b1;
               state_in = ROW;
            end
         end
         ROW: begin
            if (st.empty || st.y_done || !st.row_ok) begin
               state_in = FLUSH;
            end else begin
               cmd.row_load = 1'b1;
               state_in     = COL;
            end
         end
         COL: begin
            if (st.col_ok) begin
               cmd.piece_take = 1'b1;
            end else begin
               cmd.row_next = 1'b1;
               state_in     = ROW;
            end
         end
         FLUSH: begin
            cmd.flush = 1'b1;
            busy_in   = 1'b0;
            state_in  = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

// ----- rtl/rts_datapath.sv -----
module rts_datapath
   import rts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  cmd_type                  cmd,
   output status_type               st,
   input  logic [COORD_W-2:0]       req_src_left,
   input  logic [COORD_W-2:0]       req_src_top,
   input  logic [COORD_W-1:0]       req_src_width,
   input  logic [COORD_W-1:0]       req_src_height,
   input  logic signed [POS_W-1:0]  req_dest_x,
   input  logic signed [POS_W-1:0]  req_dest_y,
   output logic                     rsp_valid,
   output logic [IDX_W-1:0]         rsp_tile_index,
   output logic signed [POS_W-1:0]  rsp_piece_x,
   output logic signed [POS_W-1:0]  rsp_piece_y,
   output logic [SIZE_W-1:0]        rsp_piece_w,
   output logic [SIZE_W-1:0]        rsp_piece_h,
   output logic [FIX_W-1:0]         rsp_u_start,
   output logic [FIX_W-1:0]         rsp_v_start,
   output logic [FIX_W-1:0]         rsp_u_end,
   output logic [FIX_W-1:0]         rsp_v_end,
   output logic                     rsp_last_piece
);

   // Rectangle registers, loaded when a word is accepted.
   logic [COORD_W-1:0] left_ff, top_ff, right_ff, bottom_ff;
   logic [POS_W-1:0]   dx_ff, dy_ff;
   logic               empty_ff;
   logic [COORD_W-1:0] x_ff, y_ff;

   // Current tile row.
   logic [ROW_W-1:0]  ty_ff;
   logic [SIZE_W-1:0] ph_ff;
   logic [POS_W-1:0]  row_py_ff;
   logic [FIX_W-1:0]  row_v0_ff, row_v1_ff;

   // Piece held back until it is known whether another one follows.
   logic              pend_ff;
   logic [IDX_W-1:0]  pend_idx_ff;
   logic [POS_W-1:0]  pend_px_ff, pend_py_ff;
   logic [SIZE_W-1:0] pend_w_ff, pend_h_ff;
   logic [FIX_W-1:0]  pend_u0_ff, pend_v0_ff, pend_u1_ff, pend_v1_ff;

   logic              out_valid_ff, out_last_ff;
   logic [IDX_W-1:0]  out_idx_ff;
   logic [POS_W-1:0]  out_px_ff, out_py_ff;
   logic [SIZE_W-1:0] out_w_ff, out_h_ff;
   logic [FIX_W-1:0]  out_u0_ff, out_v0_ff, out_u1_ff, out_v1_ff;

   // Row evaluation at y.
   logic [COORD_W-1:0] ty_full;
   logic [ROW_W-1:0]   ty_lo;
   logic               row_last;
   logic [LOG2_W-1:0]  thl;
   logic [SIZE_W-1:0]  th;
   logic [OFF_W-1:0]   mask_h, offy;
   logic [COORD_W-1:0] rest_h;
   logic [SIZE_W-1:0]  room_h, ph;

   // Column evaluation at x.
   logic [COORD_W-1:0] tx_full;
   logic [COL_W-1:0]   tx_lo;
   logic               col_last;
   logic [LOG2_W-1:0]  twl;
   logic [SIZE_W-1:0]  tw;
   logic [OFF_W-1:0]   mask_w, offx;
   logic [COORD_W-1:0] rest_w;
   logic [SIZE_W-1:0]  room_w, pw;
   logic [IDX_W-1:0]   tile_idx;
   logic               emit;

   always_comb begin
      ty_full  = y_ff >> cfg.ihl;
      ty_lo    = ty_full[ROW_W-1:0];
      row_last = (COUNT_W'(ty_lo) == cfg.rows - COUNT_W'(1));
      thl      = row_last ? cfg.ehl : cfg.ihl;
      th       = SIZE_W'(1) << thl;
      mask_h   = ~({OFF_W{1'b1}} << cfg.ihl);
      offy     = y_ff[OFF_W-1:0] & mask_h;
      rest_h   = bottom_ff - y_ff;
      room_h   = th - SIZE_W'(offy);
      ph       = (rest_h > COORD_W'(room_h)) ? room_h : rest_h[SIZE_W-1:0];

      tx_full  = x_ff >> cfg.iwl;
      tx_lo    = tx_full[COL_W-1:0];
      col_last = (COUNT_W'(tx_lo) == cfg.cols - COUNT_W'(1));
      twl      = col_last ? cfg.ewl : cfg.iwl;
      tw       = SIZE_W'(1) << twl;
      mask_w   = ~({OFF_W{1'b1}} << cfg.iwl);
      offx     = x_ff[OFF_W-1:0] & mask_w;
      rest_w   = right_ff - x_ff;
      room_w   = tw - SIZE_W'(offx);
      pw       = (rest_w > COORD_W'(room_w)) ? room_w : rest_w[SIZE_W-1:0];
      tile_idx = IDX_W'(ty_ff) * IDX_W'(cfg.cols) + IDX_W'(tx_lo);

      st.empty  = empty_ff;
      st.y_done = (y_ff >= bottom_ff);
      st.row_ok = (ty_full < COORD_W'(cfg.rows)) && (SIZE_W'(offy) < th);
      st.col_ok = (x_ff < right_ff) && (tx_full < COORD_W'(cfg.cols))
                  && (SIZE_W'(offx) < tw);

      emit = pend_ff && (cmd.piece_take || cmd.flush);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= emit;
         if (cmd.flush) begin
            pend_ff <= 1'b0;
         end else if (cmd.piece_take) begin
            pend_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         left_ff   <= COORD_W'(req_src_left);
         top_ff    <= COORD_W'(req_src_top);
         right_ff  <= COORD_W'(COORD_W'(req_src_left) + req_src_width);
         bottom_ff <= COORD_W'(COORD_W'(req_src_top) + req_src_height);
         dx_ff     <= req_dest_x;
         dy_ff     <= req_dest_y;
         empty_ff  <= (req_src_width == '0) || (req_src_height == '0);
         y_ff      <= COORD_W'(req_src_top);
      end
      if (cmd.row_load) begin
         ty_ff     <= ty_lo;
         ph_ff     <= ph;
         row_py_ff <= dy_ff + POS_W'(y_ff - top_ff);
         row_v0_ff <= to_fix(SIZE_W'(offy), thl);
         row_v1_ff <= to_fix(SIZE_W'(offy) + ph, thl);
         x_ff      <= left_ff;
      end
      if (cmd.row_next) begin
         y_ff <= y_ff + COORD_W'(ph_ff);
      end
      if (cmd.piece_take) begin
         pend_idx_ff <= tile_idx;
         pend_px_ff  <= dx_ff + POS_W'(x_ff - left_ff);
         pend_py_ff  <= row_py_ff;
         pend_w_ff   <= pw;
         pend_h_ff   <= ph_ff;
         pend_u0_ff  <= to_fix(SIZE_W'(offx), twl);
         pend_u1_ff  <= to_fix(SIZE_W'(offx) + pw, twl);
         pend_v0_ff  <= row_v0_ff;
         pend_v1_ff  <= row_v1_ff;
         x_ff        <= x_ff + COORD_W'(pw);
      end
      if (emit) begin
         out_last_ff <= cmd.flush;
         out_idx_ff  <= pend_idx_ff;
         out_px_ff   <= pend_px_ff;
         out_py_ff   <= pend_py_ff;
         out_w_ff    <= pend_w_ff;
         out_h_ff    <= pend_h_ff;
         out_u0_ff   <= pend_u0_ff;
         out_v0_ff   <= pend_v0_ff;
         out_u1_ff   <= pend_u1_ff;
         out_v1_ff   <= pend_v1_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_last_piece = out_last_ff;
   assign rsp_tile_index = out_idx_ff;
   assign rsp_piece_x    = out_px_ff;
   assign rsp_piece_y    = out_py_ff;
   assign rsp_piece_w    = out_w_ff;
   assign rsp_piece_h    = out_h_ff;
   assign rsp_u_start    = out_u0_ff;
   assign rsp_v_start    = out_v0_ff;
   assign rsp_u_end      = out_u1_ff;
   assign rsp_v_end      = out_v1_ff;

endmodule

// ----- rtl/rect_tile_splitter.sv -----
// Rectangle to texture tile splitter.
// A rectangle word is taken when start is high and busy is low. The block
// walks the tile grid row by row and, within a row, column by column, and
// sends one result word per covered tile on the rsp_ ports. rsp_valid is
// high for exactly one cycle per word and the word must be taken then; the
// receiver has no way to stall the block. The final word of a rectangle
// carries rsp_last_piece; an empty rectangle, or one wholly outside the
// grid, gives no word at all.
// busy stays high while a taken rectangle is walked. Each tile row has a
// setup step and a closing step, with one piece per cycle between them.
// A piece is held until the next piece is taken or the walk is flushed,
// so that its last flag is known; its word appears in the following
// cycle. busy falls in the cycle that shows the last word, so the next
// rectangle may start right then.
// Grid registers are written through the csr_ port; the user must do so
// only while the block is idle, which the block does not enforce. Reset
// returns them to 64x64 tiles on a 1x1 grid and drops any walk in progress.
module rect_tile_splitter
   import rts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [COORD_W-2:0]       req_src_left,
   input  logic [COORD_W-2:0]       req_src_top,
   input  logic [COORD_W-1:0]       req_src_width,
   input  logic [COORD_W-1:0]       req_src_height,
   input  logic signed [POS_W-1:0]  req_dest_x,
   input  logic signed [POS_W-1:0]  req_dest_y,
   output logic                     rsp_valid,
   output logic [IDX_W-1:0]         rsp_tile_index,
   output logic signed [POS_W-1:0]  rsp_piece_x,
   output logic signed [POS_W-1:0]  rsp_piece_y,
   output logic [SIZE_W-1:0]        rsp_piece_w,
   output logic [SIZE_W-1:0]        rsp_piece_h,
   output logic [FIX_W-1:0]         rsp_u_start,
   output logic [FIX_W-1:0]         rsp_v_start,
   output logic [FIX_W-1:0]         rsp_u_end,
   output logic [FIX_W-1:0]         rsp_v_end,
   output logic                     rsp_last_piece,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DAT_W-1:0]     csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type st;

   rts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   rts_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .st             (st),
      .req_src_left   (req_src_left),
      .req_src_top    (req_src_top),
      .req_src_width  (req_src_width),
      .req_src_height (req_src_height),
      .req_dest_x     (req_dest_x),
      .req_dest_y     (req_dest_y),
      .rsp_valid      (rsp_valid),
      .rsp_tile_index (rsp_tile_index),
      .rsp_piece_x    (rsp_piece_x),
      .rsp_piece_y    (rsp_piece_y),
      .rsp_piece_w    (rsp_piece_w),
      .rsp_piece_h    (rsp_piece_h),
      .rsp_u_start    (rsp_u_start),
      .rsp_v_start    (rsp_v_start),
      .rsp_u_end      (rsp_u_end),
      .rsp_v_end      (rsp_v_end),
      .rsp_last_piece (rsp_last_piece)
   );

endmodule

// ----- rtl/rts_checker.sv -----
module rts_checker
   import rts_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic              rsp_last_piece,
   input logic [SIZE_W-1:0] rsp_piece_w,
   input logic [SIZE_W-1:0] rsp_piece_h
);

   // A taken rectangle keeps the block busy in the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a rectangle was taken");

   // Nothing can be ready for output right after a rectangle is taken.
   a_no_word_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result word right after a rectangle was taken");

   // The last word of a rectangle is never followed directly by another word.
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_piece) |=> !rsp_valid)
      else $error("result word directly after a last piece");

   // Words before the last one appear only while the walk is in progress.
   a_mid_word_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_piece) |-> busy)
      else $error("non-final word while the block is idle");

   a_piece_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_piece_w != '0) && (rsp_piece_h != '0))
      else $error("result word with an empty piece");

endmodule

bind rect_tile_splitter rts_checker u_rts_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_last_piece (rsp_last_piece),
   .rsp_piece_w    (rsp_piece_w),
   .rsp_piece_h    (rsp_piece_h)
);
